[src/pee_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_pkg: shared types and constants
// Sizes, action codes and derived widths for the prediction error entropy block.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int PIXEL_BITS    = 8;
  localparam int COUNT_BITS    = 18;
  localparam int FRACTION_BITS = 16;

  localparam int BIN_W       = PIXEL_BITS + 1;
  localparam int NUM_BINS    = (1 << BIN_W) - 1;
  localparam int DIFF_OFFSET = (1 << PIXEL_BITS) - 1;
  localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;

  localparam int EXP_W  = $clog2(COUNT_BITS);
  localparam int LOG_W  = EXP_W + FRACTION_BITS;
  localparam int MANT_W = FRACTION_BITS + 2;
  localparam int PROD_W = COUNT_BITS + LOG_W;
  localparam int SUM_W  = PROD_W + BIN_W;

  localparam int ENT_W = 20;
  localparam int TOT_W = 22;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_FINISH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  localparam logic KIND_ENTROPY = 1'b0;
  localparam logic KIND_BIN     = 1'b1;

endpackage

[src/pee_log2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_log2: iterative fixed point base-2 logarithm
// One squaring step per cycle, FRACTION_BITS steps per operand.
// ----------------------------------------------------------------------------
module pee_log2 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pee_pkg::COUNT_BITS-1:0] x,
  output logic                        done,
  output logic [pee_pkg::LOG_W-1:0]   result
);

  localparam int ITER_W = $clog2(pee_pkg::FRACTION_BITS + 1);

  logic                              run;
  logic [ITER_W-1:0]                 iter;
  logic [pee_pkg::MANT_W-1:0]        m;
  logic [pee_pkg::EXP_W-1:0]         e_val;
  logic [pee_pkg::MANT_W-1:0]        m0;
  logic [2*pee_pkg::MANT_W-1:0]      sq;
  logic [pee_pkg::MANT_W-1:0]        nm;
  logic [ITER_W-1:0]                 bit_pos;

  always_comb begin
    e_val = '0;
    for (int i = 1; i < pee_pkg::COUNT_BITS; i++) begin
      if (x[i]) e_val = pee_pkg::EXP_W'(i);
    end
    m0 = pee_pkg::MANT_W'({x, {pee_pkg::FRACTION_BITS{1'b0}}} >> e_val);
    sq = m * m;
    nm = sq[pee_pkg::FRACTION_BITS +: pee_pkg::MANT_W];
    bit_pos = ITER_W'(pee_pkg::FRACTION_BITS - 1) - iter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run    <= 1'b1;
        iter   <= '0;
        m      <= m0;
        result <= {e_val, {pee_pkg::FRACTION_BITS{1'b0}}};
      end else if (run) begin
        if (nm[pee_pkg::MANT_W-1]) begin
          m      <= nm >> 1;
          result <= result | (pee_pkg::LOG_W'(1) << bit_pos);
        end else begin
          m <= nm;
        end
        iter <= iter + 1'b1;
        if (iter == ITER_W'(pee_pkg::FRACTION_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/pee_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_div: restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module pee_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pee_pkg::PROD_W-1:0]     dividend,
  input  logic [pee_pkg::COUNT_BITS-1:0] divisor,
  output logic                           done,
  output logic [pee_pkg::PROD_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(pee_pkg::PROD_W);

  logic                           run;
  logic [CNT_W-1:0]               cnt;
  logic [pee_pkg::COUNT_BITS-1:0] rem;
  logic [pee_pkg::COUNT_BITS-1:0] dvs;
  logic [pee_pkg::COUNT_BITS:0]   trial;
  logic                           ge;

  always_comb begin
    trial = {rem, quotient[pee_pkg::PROD_W-1]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        rem      <= ge ? pee_pkg::COUNT_BITS'(trial - {1'b0, dvs})
                       : trial[pee_pkg::COUNT_BITS-1:0];
        quotient <= {quotient[pee_pkg::PROD_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(pee_pkg::PROD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/prediction_error_entropy.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prediction_error_entropy: previous-pixel prediction error entropy
// Histogram of pixel differences with an entropy computation on finish.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low; results are
// presented on done for one cycle and cannot be stalled. After reset, and
// after every clear action, the block sweeps the 511-bin histogram memory,
// one bin per cycle, with busy high until the sweep ends. A push of the
// first pixel of a stream only records the pixel; later pixels read the
// bin, then write it back. A read passes through ST_READ_OUT and presents
// the registered bin count on done. A finish walks all 511 bins through the
// single memory read port: an empty bin is read and checked, and a non-empty
// bin waits while the shared log2 unit runs its 16 squaring steps; then one
// more log2 for the difference count and a 39-bit restoring division finish
// the result. A finish with no differences returns at once.
// ----------------------------------------------------------------------------
module prediction_error_entropy (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action,
  input  logic [7:0]                     pixel,
  input  logic [8:0]                     bin_index,
  output logic                           done,
  output logic                           kind,
  output logic [pee_pkg::ENT_W-1:0]      entropy_q16,
  output logic [pee_pkg::TOT_W-1:0]      total_bits,
  output logic [pee_pkg::COUNT_BITS-1:0] bin_count,
  output logic                           overflow
);

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b000_0000_0001,
    ST_IDLE     = 11'b000_0000_0010,
    ST_PUSH_WR  = 11'b000_0000_0100,
    ST_READ_OUT = 11'b000_0000_1000,
    ST_FIN_RD   = 11'b000_0001_0000,
    ST_FIN_CHK  = 11'b000_0010_0000,
    ST_FIN_LOG  = 11'b000_0100_0000,
    ST_FIN_ACC  = 11'b000_1000_0000,
    ST_N_LOG    = 11'b001_0000_0000,
    ST_N_SUB    = 11'b010_0000_0000,
    ST_DIV      = 11'b100_0000_0000
  } state_t;

  localparam logic [pee_pkg::BIN_W-1:0] LAST_BIN = pee_pkg::BIN_W'(pee_pkg::NUM_BINS - 1);
  localparam logic [pee_pkg::COUNT_BITS-1:0] CMAX = pee_pkg::COUNT_MAX[pee_pkg::COUNT_BITS-1:0];

  state_t state;

  // Histogram memory
  logic [pee_pkg::COUNT_BITS-1:0] hist [pee_pkg::NUM_BINS];
  logic                           mem_we;
  logic [pee_pkg::BIN_W-1:0]      mem_wa;
  logic [pee_pkg::COUNT_BITS-1:0] mem_wd;
  logic [pee_pkg::BIN_W-1:0]      mem_ra;
  logic [pee_pkg::COUNT_BITS-1:0] rd_data;

  // Stream state
  logic [pee_pkg::PIXEL_BITS-1:0] previous_pixel;
  logic                           seen_first;
  logic [pee_pkg::COUNT_BITS-1:0] difference_count;
  logic                           saturated;

  // Sequencer registers
  logic [pee_pkg::BIN_W-1:0]      idx;
  logic [pee_pkg::BIN_W-1:0]      bin_reg;
  logic                           read_oor;
  logic [pee_pkg::COUNT_BITS-1:0] cval;
  logic [pee_pkg::PROD_W-1:0]     prod;
  logic [pee_pkg::SUM_W-1:0]      sum;
  logic [pee_pkg::PROD_W-1:0]     tval;

  logic [pee_pkg::BIN_W-1:0]      push_bin;
  logic                           accept;
  logic                           advance;
  logic                           log_start;
  logic [pee_pkg::COUNT_BITS-1:0] log_x;
  logic                           log_done;
  logic [pee_pkg::LOG_W-1:0]      log_res;
  logic                           div_start;
  logic [pee_pkg::PROD_W-1:0]     t_comb;
  logic                           div_done;
  logic [pee_pkg::PROD_W-1:0]     quotient;
  pee_pkg::action_t               act;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign act    = pee_pkg::action_t'(action);

  always_comb begin
    push_bin = pee_pkg::BIN_W'(pixel) + pee_pkg::BIN_W'(pee_pkg::DIFF_OFFSET)
             - pee_pkg::BIN_W'(previous_pixel);

    // Advance the bin walk after an empty bin or an accumulated product
    advance = (state == ST_FIN_ACC) || (state == ST_FIN_CHK && rd_data == '0);

    // Start log2 on a non-empty bin, or on the count after the last bin
    log_start = (state == ST_FIN_CHK && rd_data != '0) || (advance && idx == LAST_BIN);
    log_x     = (state == ST_FIN_CHK && rd_data != '0) ? rd_data : difference_count;

    t_comb    = (pee_pkg::SUM_W'(prod) > sum) ? pee_pkg::PROD_W'(pee_pkg::SUM_W'(prod) - sum)
                                              : '0;
    div_start = (state == ST_N_SUB);

    mem_we = 1'b0;
    mem_wa = bin_reg;
    mem_wd = rd_data + 1'b1;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx;
        mem_wd = '0;
      end
      ST_PUSH_WR: begin
        mem_we = (rd_data != CMAX);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase

    // Read a bin at acceptance so its data is ready in the next state
    if (state == ST_IDLE) begin
      mem_ra = (act == pee_pkg::ACT_READ) ? bin_index : push_bin;
    end else begin
      mem_ra = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist[mem_wa] <= mem_wd;
    rd_data <= hist[mem_ra];
  end

  pee_log2 u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  pee_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (t_comb),
    .divisor  (difference_count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      idx              <= '0;
      previous_pixel   <= '0;
      seen_first       <= 1'b0;
      difference_count <= '0;
      saturated        <= 1'b0;
      done             <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          // Sweep zeros through the histogram
          idx <= idx + 1'b1;
          if (idx == LAST_BIN) begin
            idx   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unique case (act)
              pee_pkg::ACT_PUSH: begin
                previous_pixel <= pixel;
                seen_first     <= 1'b1;
                if (seen_first) begin
                  bin_reg <= push_bin;
                  if (difference_count == CMAX) saturated <= 1'b1;
                  else difference_count <= difference_count + 1'b1;
                  state <= ST_PUSH_WR;
                end
              end
              pee_pkg::ACT_READ: begin
                read_oor <= (bin_index > LAST_BIN);
                state    <= ST_READ_OUT;
              end
              pee_pkg::ACT_CLEAR: begin
                previous_pixel   <= '0;
                seen_first       <= 1'b0;
                difference_count <= '0;
                saturated        <= 1'b0;
                idx              <= '0;
                state            <= ST_CLEAR;
              end
              pee_pkg::ACT_FINISH: begin
                if (difference_count == '0) begin
                  // No differences: answer at once
                  done        <= 1'b1;
                  kind        <= pee_pkg::KIND_ENTROPY;
                  entropy_q16 <= '0;
                  total_bits  <= '0;
                  bin_count   <= '0;
                  overflow    <= saturated;
                end else begin
                  sum   <= '0;
                  idx   <= '0;
                  state <= ST_FIN_RD;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_PUSH_WR: begin
          if (rd_data == CMAX) saturated <= 1'b1;
          state <= ST_IDLE;
        end
        ST_READ_OUT: begin
          done        <= 1'b1;
          kind        <= pee_pkg::KIND_BIN;
          entropy_q16 <= '0;
          total_bits  <= '0;
          bin_count   <= read_oor ? '0 : rd_data;
          overflow    <= saturated;
          state       <= ST_IDLE;
        end
        ST_FIN_RD: begin
          state <= ST_FIN_CHK;
        end
        ST_FIN_CHK: begin
          cval <= rd_data;
          if (rd_data != '0) state <= ST_FIN_LOG;
        end
        ST_FIN_LOG: begin
          if (log_done) begin
            prod  <= cval * log_res;
            state <= ST_FIN_ACC;
          end
        end
        ST_FIN_ACC: begin
          sum <= sum + pee_pkg::SUM_W'(prod);
        end
        ST_N_LOG: begin
          if (log_done) begin
            prod  <= difference_count * log_res;
            state <= ST_N_SUB;
          end
        end
        ST_N_SUB: begin
          tval  <= t_comb;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            done        <= 1'b1;
            kind        <= pee_pkg::KIND_ENTROPY;
            entropy_q16 <= quotient[pee_pkg::ENT_W-1:0];
            total_bits  <= tval[pee_pkg::FRACTION_BITS +: pee_pkg::TOT_W];
            bin_count   <= '0;
            overflow    <= saturated;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Step to the next bin, or hand over to the count log2 after the last
      if (advance) begin
        if (idx == LAST_BIN) begin
          state <= ST_N_LOG;
        end else begin
          idx   <= idx + 1'b1;
          state <= ST_FIN_RD;
        end
      end
    end
  end

endmodule
